// ===== rtl/core/fsmk_pkg.sv =====
package fsmk_pkg;

    localparam int MAX_JOBS_DEF     = 64;
    localparam int MAX_MACHINES_DEF = 16;

    localparam int JOB_W   = 6;
    localparam int MACH_W  = 4;
    localparam int PTIME_W = 16;
    localparam int TIME_W  = 24;
    localparam int CFG_W   = 5;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SEQ   = 1'b1;

endpackage

// ===== rtl/core/flow_shop_makespan.sv =====
// Channel   Dir  Handshake            Word
// in        in   in_valid / in_stall  req_type, job, machine, proc_time, first_job, last_job
// out       out  out_valid / out_stall makespan
// cfg       in   cfg_we               cfg_data (num_machines)
//
// A table write is taken in ST_IDLE. A sequence word walks ST_RUN over the nm machines in
// use, then ST_OUT when it carries last_job; in_stall is high outside ST_IDLE. The work
// is done by one shared max-add-saturate unit stepping machine by machine over the
// single read port of the processing time table.
// Async reset clears control state and completion valid bits, not time or table memories.
// A stalled result sits in the output register while the next word is taken.
module flow_shop_makespan
    import fsmk_pkg::*;
#(
    parameter int MAX_JOBS     = MAX_JOBS_DEF,
    parameter int MAX_MACHINES = MAX_MACHINES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [JOB_W-1:0]     job,
    input  logic [MACH_W-1:0]    machine,
    input  logic [PTIME_W-1:0]   proc_time,
    input  logic                 first_job,
    input  logic                 last_job,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TIME_W-1:0]    makespan
);

    localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MIW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int NW    = $clog2(MAX_MACHINES + 1);
    localparam int DEPTH = MAX_JOBS * MAX_MACHINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JOB_N  = 1 << JOB_W;
    localparam int MACH_N = 1 << MACH_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    // index folding, constant tables
    logic [JW-1:0]  job_mod  [JOB_N];
    logic [MIW-1:0] mach_mod [MACH_N];

    for (genvar gi = 0; gi < JOB_N; gi++) begin : g_job_mod
        assign job_mod[gi] = JW'(gi % MAX_JOBS);
    end
    for (genvar gm = 0; gm < MACH_N; gm++) begin : g_mach_mod
        assign mach_mod[gm] = MIW'(gm % MAX_MACHINES);
    end

    logic [PTIME_W-1:0] tbl_mem  [DEPTH];
    logic [TIME_W-1:0]  comp_mem [MAX_MACHINES];

    state_t              state_reg,     state_next;
    logic [CFG_W-1:0]    nmach_cfg_reg, nmach_cfg_next;
    logic [JW-1:0]       job_reg,       job_next;
    logic                last_reg,      last_next;
    logic [NW-1:0]       nm_reg,        nm_next;
    logic [NW-1:0]       m_iss_reg,     m_iss_next;
    logic [MIW-1:0]      m_wb_reg,      m_wb_next;
    logic                rd_vld_reg,    rd_vld_next;
    logic                cpv_rd_reg,    cpv_rd_next;
    logic [TIME_W-1:0]   prev_reg,      prev_next;
    logic [TIME_W-1:0]   res_reg,       res_next;
    logic [MAX_MACHINES-1:0] comp_vld_reg, comp_vld_next;
    logic                out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]   makespan_reg,  makespan_next;

    logic [PTIME_W-1:0]  tt_rd_reg;
    logic [TIME_W-1:0]   cp_rd_reg;

    logic [NW-1:0]       nm_eff;
    logic                issue;
    logic                tbl_we;
    logic                comp_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [MIW-1:0]      iss_idx;
    logic [TIME_W-1:0]   cp_eff;
    logic [TIME_W-1:0]   mx;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   cur;

    // zero acts as one machine, anything above the build size clamps
    always_comb
    begin
        if (nmach_cfg_reg == '0)
            nm_eff = NW'(1);
        else if (32'(nmach_cfg_reg) > 32'(MAX_MACHINES))
            nm_eff = NW'(MAX_MACHINES);
        else
            nm_eff = NW'(nmach_cfg_reg);
    end

    assign iss_idx = m_iss_reg[MIW-1:0];
    assign issue   = (state_reg == ST_RUN) && (m_iss_reg < nm_reg);
    assign wr_addr = AW'(32'(job_mod[job]) * 32'(MAX_MACHINES) + 32'(mach_mod[machine]));
    assign rd_addr = AW'(32'(job_reg) * 32'(MAX_MACHINES) + 32'(iss_idx));

    // shared max-add with saturation
    assign cp_eff = cpv_rd_reg ? cp_rd_reg : '0;
    assign mx     = (prev_reg > cp_eff) ? prev_reg : cp_eff;
    assign sum    = {1'b0, mx} + (TIME_W+1)'(tt_rd_reg);
    assign cur    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        nmach_cfg_next = nmach_cfg_reg;
        job_next       = job_reg;
        last_next      = last_reg;
        nm_next        = nm_reg;
        m_iss_next     = m_iss_reg;
        m_wb_next      = m_wb_reg;
        rd_vld_next    = 1'b0;
        cpv_rd_next    = 1'b0;
        prev_next      = prev_reg;
        res_next       = res_reg;
        comp_vld_next  = comp_vld_reg;
        out_valid_next = out_valid_reg;
        makespan_next  = makespan_reg;
        tbl_we         = 1'b0;
        comp_we        = 1'b0;

        if (cfg_we)
            nmach_cfg_next = cfg_data;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        tbl_we = 1'b1;
                    end
                    else
                    begin
                        job_next   = job_mod[job];
                        last_next  = last_job;
                        nm_next    = nm_eff;
                        m_iss_next = '0;
                        prev_next  = '0;
                        if (first_job)
                            comp_vld_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // read of machine m+1 overlaps update of machine m
                if (issue)
                begin
                    m_iss_next  = m_iss_reg + NW'(1);
                    rd_vld_next = 1'b1;
                    cpv_rd_next = comp_vld_reg[iss_idx];
                    m_wb_next   = iss_idx;
                end
                if (rd_vld_reg)
                begin
                    comp_we                 = 1'b1;
                    comp_vld_next[m_wb_reg] = 1'b1;
                    prev_next               = cur;
                    if (NW'(m_wb_reg) == nm_reg - NW'(1))
                    begin
                        if (last_reg)
                        begin
                            res_next   = cur;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    makespan_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nmach_cfg_reg <= CFG_W'(1);
            job_reg       <= '0;
            last_reg      <= 1'b0;
            nm_reg        <= '0;
            m_iss_reg     <= '0;
            m_wb_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            cpv_rd_reg    <= 1'b0;
            prev_reg      <= '0;
            res_reg       <= '0;
            comp_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            makespan_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nmach_cfg_reg <= nmach_cfg_next;
            job_reg       <= job_next;
            last_reg      <= last_next;
            nm_reg        <= nm_next;
            m_iss_reg     <= m_iss_next;
            m_wb_reg      <= m_wb_next;
            rd_vld_reg    <= rd_vld_next;
            cpv_rd_reg    <= cpv_rd_next;
            prev_reg      <= prev_next;
            res_reg       <= res_next;
            comp_vld_reg  <= comp_vld_next;
            out_valid_reg <= out_valid_next;
            makespan_reg  <= makespan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[wr_addr] <= proc_time;
        if (issue)
        begin
            tt_rd_reg <= tbl_mem[rd_addr];
            cp_rd_reg <= comp_mem[iss_idx];
        end
        if (comp_we)
            comp_mem[m_wb_reg] <= cur;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign makespan  = makespan_reg;

endmodule
